// File: hw/rtl/srhs_pkg.sv
// ----------------------------------------------------------------------------
// srhs_pkg: shared types and constants for the half-step ramp driver
// Field widths, command codes, ramp constants and the coil decode table.
// ----------------------------------------------------------------------------
package srhs_pkg;

  localparam int FUNC_W    = 2;
  localparam int MOVE_W    = 17;
  localparam int POS_W     = 16;
  localparam int PER_W     = 16;
  localparam int STEPS_W   = 16;
  localparam int PHASE_W   = 3;
  localparam int COIL_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int WINDOW_W  = 11;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GO      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_POS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_PERIOD   = 1'b1;

  localparam logic [PER_W-1:0]    START_PERIOD_RST = 16'd5000;
  localparam logic [PER_W-1:0]    END_PERIOD_RST   = 16'd1000;
  localparam logic [WINDOW_W-1:0] WINDOW_RST       = 11'd80;

  localparam logic [PER_W-1:0] ACCEL_DELTA = 16'd50;
  localparam logic [PER_W-1:0] DECEL_DELTA = 16'd100;

  // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for any 15-bit x
  localparam logic [14:0] RECIP_25    = 15'd20972;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [PHASE_W-1:0] PHASE_FWD = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_BWD = 3'd7;

  typedef enum logic [1:0] {
    ST_STOP  = 2'd0,
    ST_ACCEL = 2'd1,
    ST_RUN   = 2'd2,
    ST_DECEL = 2'd3
  } run_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [MOVE_W-1:0] move_steps;
    logic [POS_W-1:0]         new_position;
  } item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    run_state_t        motor_state;
    logic [POS_W-1:0]  position;
    logic              step_taken;
  } result_t;

  typedef struct packed {
    logic [PER_W-1:0]    start_period;
    logic [PER_W-1:0]    end_period;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

  function automatic logic [COIL_W-1:0] coil_drive(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] c;
    case (phase)
      3'd0:    c = 4'd6;
      3'd1:    c = 4'd4;
      3'd2:    c = 4'd12;
      3'd3:    c = 4'd8;
      3'd4:    c = 4'd9;
      3'd5:    c = 4'd1;
      3'd6:    c = 4'd3;
      3'd7:    c = 4'd2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/srhs_in_if.sv
// ----------------------------------------------------------------------------
// srhs_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface srhs_in_if;
  import srhs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [MOVE_W-1:0] move_steps;
  logic [POS_W-1:0]         new_position;

  modport source(output valid, func, move_steps, new_position, input ready);
  modport sink(input valid, func, move_steps, new_position, output ready);
endinterface

// File: hw/rtl/srhs_out_if.sv
// ----------------------------------------------------------------------------
// srhs_out_if: result channel
// Valid/ready channel carrying one status item per command.
// ----------------------------------------------------------------------------
interface srhs_out_if;
  import srhs_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic [1:0]        motor_state;
  logic [POS_W-1:0]  position;
  logic              step_taken;

  modport source(output valid, coils, motor_state, position, step_taken, input ready);
  modport sink(input valid, coils, motor_state, position, step_taken, output ready);
endinterface

// File: hw/rtl/srhs_cfg_if.sv
// ----------------------------------------------------------------------------
// srhs_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface srhs_cfg_if;
  import srhs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [PER_W-1:0]     wdata;

  modport source(output valid, idx, wdata, input ready);
  modport sink(input valid, idx, wdata, output ready);
endinterface

// File: hw/rtl/srhs_cfg.sv
// ----------------------------------------------------------------------------
// srhs_cfg: ramp configuration registers
// Holds start and end period and the precomputed deceleration window.
// ----------------------------------------------------------------------------
module srhs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [srhs_pkg::CFG_IDX_W-1:0]     wr_idx,
  input  logic [srhs_pkg::PER_W-1:0]         wr_data,
  output srhs_pkg::cfg_t                     cfg
);
  import srhs_pkg::*;

  cfg_t                    cfg_r;
  logic [PER_W-1:0]        start_nxt;
  logic [PER_W-1:0]        end_nxt;
  logic [PER_W-1:0]        diff;
  logic [29:0]             prod;
  logic [WINDOW_W-1:0]     window_nxt;

  always_comb begin
    start_nxt = cfg_r.start_period;
    end_nxt   = cfg_r.end_period;
    if (wr_en) begin
      case (wr_idx)
        REG_START_PERIOD: start_nxt = wr_data;
        REG_END_PERIOD:   end_nxt   = wr_data;
        default:          ;
      endcase
    end
    // window = (start - end) / 50, done as (diff / 2) / 25 by reciprocal
    diff = start_nxt - end_nxt;
    prod = 30'(diff[PER_W-1:1]) * 30'(RECIP_25);
    window_nxt = (start_nxt > end_nxt) ? prod[RECIP_SHIFT +: WINDOW_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_period <= START_PERIOD_RST;
      cfg_r.end_period   <= END_PERIOD_RST;
      cfg_r.window       <= WINDOW_RST;
    end else if (wr_en) begin
      cfg_r.start_period <= start_nxt;
      cfg_r.end_period   <= end_nxt;
      cfg_r.window       <= window_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/srhs_core.sv
// ----------------------------------------------------------------------------
// srhs_core: motion state and step logic
// Applies one command item per cycle while advance is high to the motor state and forms its result.
// ----------------------------------------------------------------------------
module srhs_core #(
  parameter int STEPS_PER_MIN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  srhs_pkg::item_t   item,
  input  srhs_pkg::cfg_t    cfg,
  output srhs_pkg::result_t result
);
  import srhs_pkg::*;

  localparam logic [POS_W-1:0] DIAL_FULL = POS_W'(12 * 60 * STEPS_PER_MIN);

  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [PHASE_W-1:0] phase_r,  phase_nxt;
  logic [STEPS_W-1:0] walked_r, walked_nxt;
  logic [STEPS_W-1:0] goal_r,   goal_nxt;
  logic [PER_W-1:0]   period_r, period_nxt;
  logic [PER_W-1:0]   tick_r,   tick_nxt;
  logic               bwd_r,    bwd_nxt;
  logic               live_r,   live_nxt;
  run_state_t         run_r,    run_nxt;

  logic [PER_W-1:0]          tick_inc;
  logic                      do_step;
  logic [POS_W-1:0]          pos_step;
  logic [STEPS_W-1:0]        walked_inc;
  logic [PER_W-1:0]          per_acc;
  logic [PER_W:0]            per_sum;
  logic signed [STEPS_W:0]   remaining;
  logic signed [STEPS_W:0]   window_s;
  logic [MOVE_W-1:0]         mag;

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    walked_nxt = walked_r;
    goal_nxt   = goal_r;
    period_nxt = period_r;
    tick_nxt   = tick_r;
    bwd_nxt    = bwd_r;
    live_nxt   = live_r;
    run_nxt    = run_r;

    tick_inc = tick_r + 1'b1;
    do_step  = (item.func == FUNC_TICK) && (run_r != ST_STOP) && (tick_inc >= period_r);

    // dial wrap keeps the asymmetric rules: forward wraps at full, backward at one
    if (bwd_r) begin
      pos_step = (pos_r <= POS_W'(1)) ? DIAL_FULL : pos_r - 1'b1;
    end else begin
      pos_step = (({1'b0, pos_r} + 1'b1) >= {1'b0, DIAL_FULL}) ? '0 : pos_r + 1'b1;
    end
    walked_inc = walked_r + 1'b1;
    per_acc    = (period_r >= ACCEL_DELTA) ? period_r - ACCEL_DELTA : '0;
    if (period_r <= cfg.end_period) begin
      per_acc = period_r;
    end
    per_sum   = {1'b0, per_acc} + {1'b0, DECEL_DELTA};
    remaining = $signed({1'b0, goal_r}) - $signed({1'b0, walked_inc});
    window_s  = $signed({{(STEPS_W + 1 - WINDOW_W){1'b0}}, cfg.window});

    mag = item.move_steps[MOVE_W-1] ? MOVE_W'(-item.move_steps) : item.move_steps;

    case (item.func)
      FUNC_TICK: begin
        if (run_r != ST_STOP) begin
          tick_nxt = tick_inc;
          if (do_step) begin
            tick_nxt   = '0;
            pos_nxt    = pos_step;
            phase_nxt  = phase_r + (bwd_r ? PHASE_BWD : PHASE_FWD);
            walked_nxt = walked_inc;
            live_nxt   = 1'b1;
            period_nxt = per_acc;
            run_nxt    = (period_r > cfg.end_period) ? ST_ACCEL : ST_RUN;
            if (remaining < window_s) begin
              period_nxt = per_sum[PER_W] ? '1 : per_sum[PER_W-1:0];
              run_nxt    = ST_DECEL;
            end
            if (walked_inc >= goal_r) begin
              live_nxt = 1'b0;
              run_nxt  = ST_STOP;
            end
          end
        end
      end
      FUNC_GO: begin
        bwd_nxt    = item.move_steps[MOVE_W-1];
        goal_nxt   = mag[MOVE_W-1] ? '1 : mag[STEPS_W-1:0];
        walked_nxt = '0;
        period_nxt = cfg.start_period;
        tick_nxt   = '0;
        run_nxt    = ST_ACCEL;
      end
      FUNC_SET_POS: begin
        pos_nxt = item.new_position;
      end
      default: ;
    endcase

    result.coils       = live_nxt ? coil_drive(phase_nxt) : '0;
    result.motor_state = run_nxt;
    result.position    = pos_nxt;
    result.step_taken  = do_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= '0;
      walked_r <= '0;
      goal_r   <= '0;
      period_r <= '0;
      tick_r   <= '0;
      bwd_r    <= 1'b0;
      live_r   <= 1'b0;
      run_r    <= ST_STOP;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      walked_r <= walked_nxt;
      goal_r   <= goal_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      bwd_r    <= bwd_nxt;
      live_r   <= live_nxt;
      run_r    <= run_nxt;
    end
  end

  a_walk_within_goal: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != ST_STOP) |-> (walked_r <= goal_r))
    else $error("walked count passed the goal while moving");

  a_stop_releases_coils: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r == ST_STOP) |-> !live_r)
    else $error("coils energized while stopped");

  a_step_restarts_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && do_step) |=> (tick_r == '0))
    else $error("tick counter not restarted after a step");

endmodule

// File: hw/rtl/stepper_ramp_half_step_driver.sv
// ----------------------------------------------------------------------------
// stepper_ramp_half_step_driver: half-step stepper driver with ramped period
// Command in, one status item out per command, with register write port.
// ----------------------------------------------------------------------------
// Every command item (tick, go, set position) yields exactly one status item.
// The block takes one item per clock while the output is not stalled: an
// item is captured in the input register, and once the output register is
// free it is applied to the motion state while its status is loaded into
// the output register, where it waits for the sink. The core forms the
// status combinationally and registers its state on each advance; while the
// output waits, one more command is held in the input register. Register
// writes take effect at once; write them only while no command is in flight.
module stepper_ramp_half_step_driver #(
  parameter int STEPS_PER_MIN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  srhs_in_if.sink   in_ch,
  srhs_out_if.source out_ch,
  srhs_cfg_if.sink  cfg_ch
);
  import srhs_pkg::*;

  logic    in_valid_r;
  item_t   in_data_r;
  logic    out_valid_r;
  result_t out_data_r;
  logic    advance;
  result_t result;
  cfg_t    cfg;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  srhs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid && cfg_ch.ready),
    .wr_idx  (cfg_ch.idx),
    .wr_data (cfg_ch.wdata),
    .cfg     (cfg)
  );

  srhs_core #(
    .STEPS_PER_MIN (STEPS_PER_MIN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r.func         <= in_ch.func;
      in_data_r.move_steps   <= in_ch.move_steps;
      in_data_r.new_position <= in_ch.new_position;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.coils       = out_data_r.coils;
  assign out_ch.motor_state = out_data_r.motor_state;
  assign out_ch.position    = out_data_r.position;
  assign out_ch.step_taken  = out_data_r.step_taken;

endmodule
